>>> hdl/scg_pkg.sv
// ----------------------------------------------------------------------------
// Scaled Scharr gradient package
// Shared widths, types, register codes and arithmetic helpers for the
// gradient core and its submodules.
// ----------------------------------------------------------------------------
package scg_pkg;

  // Default line length of the line store.
  localparam int MAX_WIDTH_DEFAULT = 1024;

  // Field widths.
  localparam int PIXEL_W      = 8;
  localparam int GRAD_W       = 14;
  localparam int ROW_W        = 16;
  localparam int COL_W        = 10;
  localparam int SMOOTH_W     = 14;
  localparam int DIFF_W       = 9;
  localparam int WIDE_W       = 15;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

  // Register reset values.
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(1024);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

  // Kernel weights of the smoothing tap.
  localparam int SMOOTH_EDGE   = 6;
  localparam int SMOOTH_CENTER = 20;

  // Result slots of one item, in output order.
  localparam int RESULTS_MAX = 4;
  localparam int SLOT_W      = 2;
  localparam int SLOT_A_PREV = 0;  // row above, previous column
  localparam int SLOT_A_LAST = 1;  // row above, last column
  localparam int SLOT_B_PREV = 2;  // final row, previous column
  localparam int SLOT_B_LAST = 3;  // final row, last column

  typedef logic [PIXEL_W-1:0]       pixel_t;
  typedef logic [SMOOTH_W-1:0]      smooth_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic [ROW_W-1:0]         row_t;
  typedef logic [COL_W-1:0]         col_t;

  // One line store word: the pixel one row back and the one two rows back.
  typedef struct packed {
    pixel_t one;
    pixel_t two;
  } line_pair_t;

  // Position flags of the item in the window stage.
  typedef struct packed {
    logic row_ge1;
    logic row_ge2;
    logic col_is0;
    logic col_is1;
    logic last_col;
    logic last_row;
  } item_flags_t;

  typedef struct packed {
    grad_t grad_x;
    grad_t grad_y;
    row_t  row;
    col_t  col;
  } result_t;

  // All results caused by one item.
  typedef struct packed {
    logic [RESULTS_MAX-1:0] valid;
    logic                   frame_end;
    result_t [RESULTS_MAX-1:0] entry;
  } bundle_t;

  // Vertical smoothing of one column: 6*(top+bot) + 20*mid.
  function automatic smooth_t smooth_col(pixel_t top, pixel_t mid, pixel_t bot);
    smooth_t edge_sum;
    edge_sum = smooth_t'(top) + smooth_t'(bot);
    return smooth_t'(edge_sum * smooth_t'(SMOOTH_EDGE) + smooth_t'(mid) * smooth_t'(SMOOTH_CENTER));
  endfunction

  // Vertical difference of one column: bot - top.
  function automatic diff_t diff_col(pixel_t top, pixel_t bot);
    return diff_t'({1'b0, bot}) - diff_t'({1'b0, top});
  endfunction

  // Horizontal difference of smoothed columns.
  function automatic grad_t x_grad(smooth_t right, smooth_t left);
    wide_t d;
    d = wide_t'({1'b0, right}) - wide_t'({1'b0, left});
    return grad_t'(d);
  endfunction

  // Horizontal smoothing of column differences.
  function automatic grad_t y_grad(diff_t left, diff_t right, diff_t center);
    wide_t edge_sum;
    wide_t total;
    edge_sum = wide_t'(left) + wide_t'(right);
    total    = edge_sum * wide_t'(SMOOTH_EDGE) + wide_t'(center) * wide_t'(SMOOTH_CENTER);
    return grad_t'(total);
  endfunction

endpackage

>>> hdl/scg_ifs.sv
// ----------------------------------------------------------------------------
// Scaled Scharr gradient channel interfaces
// Valid/ready channels for pixels in, gradient results out and register
// writes.
// ----------------------------------------------------------------------------

// Pixel channel.
interface scg_pixel_if;
  logic            valid;
  logic            ready;
  scg_pkg::pixel_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// Gradient result channel.
interface scg_grad_if;
  logic           valid;
  logic           ready;
  scg_pkg::grad_t grad_x;
  scg_pkg::grad_t grad_y;
  scg_pkg::row_t  out_row;
  scg_pkg::col_t  out_col;
  logic           last_of_run;
  logic           frame_end;

  modport source (output valid, output grad_x, output grad_y, output out_row,
                  output out_col, output last_of_run, output frame_end, input ready);
  modport sink   (input valid, input grad_x, input grad_y, input out_row,
                  input out_col, input last_of_run, input frame_end, output ready);
endinterface

// Register write channel.
interface scg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [scg_pkg::CFG_INDEX_W-1:0]  index;
  logic [scg_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/scaled_scharr_gradient_core.sv
// ----------------------------------------------------------------------------
// Scaled Scharr gradient core
// Streams grey pixels in raster order and produces signed x and y gradients
// of a separable 3x3 kernel, using a line store of the two previous rows.
// ----------------------------------------------------------------------------
//
//   Channel   Role     Payload
//   -------   ------   --------------------------------------------------
//   pixels    sink     pixel
//   grads     source   grad_x, grad_y, out_row, out_col, last_of_run,
//                      frame_end
//   cfg       sink     index, data (0: image_width, 1: image_height)
//
// An item is accepted every cycle while each item causes at most one result
// and the output is ready; the result buffer drains one result per cycle
// while the output is ready, so an item with more than one result holds the
// input until all but its last result have gone out, up to four results at
// the last column of the final row. A pixel passes the window stage and the
// result buffer before its first result. The line store is read at accept
// and written back when the item leaves the window stage. Reset clears the
// position counters and windows and sets the registers to 1024 and 480; the
// line store is not cleared. Output stalls back up to the input through ready.
module scaled_scharr_gradient_core #(
  parameter int MAX_WIDTH = scg_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  scg_pixel_if.sink    pixels,
  scg_grad_if.source   grads,
  scg_cfg_if.sink      cfg
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = (AW + 1 > scg_pkg::WIDTH_REG_W) ? AW + 1 : scg_pkg::WIDTH_REG_W;

  // Configuration registers.
  logic [scg_pkg::WIDTH_REG_W-1:0]  image_width;
  logic [scg_pkg::HEIGHT_REG_W-1:0] image_height;

  // Position of the next pixel.
  logic [AW-1:0]  col_count;
  scg_pkg::row_t  row_count;

  // Window stage registers.
  logic                 b_valid;
  scg_pkg::pixel_t      b_pixel;
  logic [AW-1:0]        b_col;
  scg_pkg::row_t        b_row;
  scg_pkg::item_flags_t b_flags;

  logic                 accept;
  logic                 b_fire;
  logic                 buf_can_load;
  logic [CW-1:0]        width_ext;
  logic [CW-1:0]        width_eff;
  scg_pkg::row_t        height_eff;
  scg_pkg::item_flags_t flags;
  scg_pkg::line_pair_t  line_rd;
  scg_pkg::line_pair_t  line_wr;
  scg_pkg::bundle_t     bundle;

  // Register writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= scg_pkg::WIDTH_RESET;
      image_height <= scg_pkg::HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        scg_pkg::REG_IMAGE_WIDTH: begin
          image_width <= cfg.data[scg_pkg::WIDTH_REG_W-1:0];
        end
        scg_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= cfg.data[scg_pkg::HEIGHT_REG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Effective frame size and position flags of the incoming pixel.
  always_comb begin
    width_ext = CW'(image_width);
    if (width_ext == '0) begin
      width_eff = CW'(1);
    end else if (width_ext > CW'(MAX_WIDTH)) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    height_eff = (image_height == '0) ? scg_pkg::row_t'(1) : image_height;

    flags.row_ge1  = (row_count != '0);
    flags.row_ge2  = (row_count > scg_pkg::row_t'(1));
    flags.col_is0  = (col_count == '0);
    flags.col_is1  = (col_count == AW'(1));
    flags.last_col = ((CW'(col_count) + CW'(1)) >= width_eff);
    flags.last_row = (({1'b0, row_count} + 17'd1) >= {1'b0, height_eff});
  end

  // Handshake: the window stage moves when the result buffer can take it.
  assign b_fire        = b_valid && buf_can_load;
  assign pixels.ready  = !b_valid || b_fire;
  assign accept        = pixels.valid && pixels.ready;

  // Raster position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (flags.last_col) begin
        col_count <= '0;
        row_count <= flags.last_row ? '0 : row_count + scg_pkg::row_t'(1);
      end else begin
        col_count <= col_count + AW'(1);
      end
    end
  end

  // Window stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  // Window stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      b_pixel <= pixels.pixel;
      b_col   <= col_count;
      b_row   <= row_count;
      b_flags <= flags;
    end
  end

  // Line store write-back: the row one back moves to two back.
  assign line_wr.one = b_pixel;
  assign line_wr.two = line_rd.one;

  scg_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (AW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_data (line_rd),
    .wr_en   (b_fire),
    .wr_addr (b_col),
    .wr_data (line_wr)
  );

  scg_window u_window (
    .clk    (clk),
    .rst    (rst),
    .fire   (b_fire),
    .flags  (b_flags),
    .pixel  (b_pixel),
    .line   (line_rd),
    .row    (b_row),
    .col    (scg_pkg::COL_W'(32'(b_col))),
    .bundle (bundle)
  );

  scg_result_buf u_result_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (b_fire),
    .bundle   (bundle),
    .can_load (buf_can_load),
    .grads    (grads)
  );

endmodule

>>> hdl/scg_line_mem.sv
// ----------------------------------------------------------------------------
// Scaled Scharr gradient line store
// One-port-read, one-port-write synchronous memory holding the two previous
// rows, with a registered read and write-to-read bypass.
// ----------------------------------------------------------------------------
module scg_line_mem #(
  parameter int DEPTH  = scg_pkg::MAX_WIDTH_DEFAULT,
  parameter int ADDR_W = 10
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output scg_pkg::line_pair_t rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  scg_pkg::line_pair_t wr_data
);

  scg_pkg::line_pair_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; a write to the same entry in the same cycle is passed through.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

>>> hdl/scg_window.sv
// ----------------------------------------------------------------------------
// Scaled Scharr gradient window
// Column sums and differences of the last three columns for the row above
// and for the final row, and the results that one item produces.
// ----------------------------------------------------------------------------
module scg_window (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  scg_pkg::item_flags_t flags,
  input  scg_pkg::pixel_t      pixel,
  input  scg_pkg::line_pair_t  line,
  input  scg_pkg::row_t        row,
  input  scg_pkg::col_t        col,
  output scg_pkg::bundle_t     bundle
);

  // Three columns per lane; index 2 is the newest.
  scg_pkg::smooth_t sa [3];
  scg_pkg::diff_t   da [3];
  scg_pkg::smooth_t sb [3];

  scg_pkg::pixel_t  top_a;
  scg_pkg::pixel_t  top_b;
  scg_pkg::smooth_t sa_new;
  scg_pkg::diff_t   da_new;
  scg_pkg::smooth_t sb_new;
  scg_pkg::row_t    row_above;
  scg_pkg::col_t    col_prev;

  // New column values; rows above the frame mirror onto rows inside it.
  always_comb begin
    top_a  = flags.row_ge2 ? line.two : pixel;
    sa_new = scg_pkg::smooth_col(top_a, line.one, pixel);
    da_new = scg_pkg::diff_col(top_a, pixel);
    top_b  = flags.row_ge1 ? line.one : pixel;
    sb_new = scg_pkg::smooth_col(top_b, pixel, top_b);
  end

  // Results of this item, in output order.
  always_comb begin
    row_above = row - scg_pkg::row_t'(1);
    col_prev  = col - scg_pkg::col_t'(1);

    bundle.valid[scg_pkg::SLOT_A_PREV] = flags.row_ge1 && !flags.col_is0;
    bundle.valid[scg_pkg::SLOT_A_LAST] = flags.row_ge1 && flags.last_col;
    bundle.valid[scg_pkg::SLOT_B_PREV] = flags.last_row && !flags.col_is0;
    bundle.valid[scg_pkg::SLOT_B_LAST] = flags.last_row && flags.last_col;
    bundle.frame_end = flags.last_row && flags.last_col;

    // Row above, previous column; at column one the left neighbor mirrors.
    bundle.entry[scg_pkg::SLOT_A_PREV].grad_x =
      scg_pkg::x_grad(sa_new, flags.col_is1 ? sa_new : sa[1]);
    bundle.entry[scg_pkg::SLOT_A_PREV].grad_y =
      scg_pkg::y_grad(flags.col_is1 ? da_new : da[1], da_new, da[2]);
    bundle.entry[scg_pkg::SLOT_A_PREV].row = row_above;
    bundle.entry[scg_pkg::SLOT_A_PREV].col = col_prev;

    // Row above, last column; both neighbors mirror onto the same column.
    bundle.entry[scg_pkg::SLOT_A_LAST].grad_x = '0;
    bundle.entry[scg_pkg::SLOT_A_LAST].grad_y = flags.col_is0 ?
      scg_pkg::y_grad(da_new, da_new, da_new) : scg_pkg::y_grad(da[2], da[2], da_new);
    bundle.entry[scg_pkg::SLOT_A_LAST].row = row_above;
    bundle.entry[scg_pkg::SLOT_A_LAST].col = col;

    // Final row: the mirrored rows cancel, so the vertical gradient is zero.
    bundle.entry[scg_pkg::SLOT_B_PREV].grad_x =
      scg_pkg::x_grad(sb_new, flags.col_is1 ? sb_new : sb[1]);
    bundle.entry[scg_pkg::SLOT_B_PREV].grad_y = '0;
    bundle.entry[scg_pkg::SLOT_B_PREV].row = row;
    bundle.entry[scg_pkg::SLOT_B_PREV].col = col_prev;

    bundle.entry[scg_pkg::SLOT_B_LAST].grad_x = '0;
    bundle.entry[scg_pkg::SLOT_B_LAST].grad_y = '0;
    bundle.entry[scg_pkg::SLOT_B_LAST].row = row;
    bundle.entry[scg_pkg::SLOT_B_LAST].col = col;
  end

  // Shift the windows once per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        sa[i] <= '0;
        da[i] <= '0;
        sb[i] <= '0;
      end
    end else if (fire) begin
      sa[0] <= sa[1];
      sa[1] <= sa[2];
      sa[2] <= sa_new;
      da[0] <= da[1];
      da[1] <= da[2];
      da[2] <= da_new;
      sb[0] <= sb[1];
      sb[1] <= sb[2];
      sb[2] <= sb_new;
    end
  end

endmodule

>>> hdl/scg_result_buf.sv
// ----------------------------------------------------------------------------
// Scaled Scharr gradient result buffer
// Holds the results of one item and hands them out one per cycle, while the
// output is ready, in slot order, marking the last one of the item and of the frame.
// ----------------------------------------------------------------------------
module scg_result_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  scg_pkg::bundle_t  bundle,
  output logic              can_load,
  scg_grad_if.source        grads
);

  logic [scg_pkg::RESULTS_MAX-1:0] valid;
  logic                            frame_end;
  scg_pkg::result_t [scg_pkg::RESULTS_MAX-1:0] entry;

  logic [scg_pkg::SLOT_W-1:0] slot;
  logic                       one_left;
  logic                       take;

  // Lowest pending slot goes out first.
  always_comb begin
    slot = '0;
    for (int i = scg_pkg::RESULTS_MAX - 1; i >= 0; i--) begin
      if (valid[i]) begin
        slot = scg_pkg::SLOT_W'(i);
      end
    end
    one_left = (valid != '0) &&
               ((valid & (valid - scg_pkg::RESULTS_MAX'(1))) == '0);
    take     = grads.valid && grads.ready;
    can_load = (valid == '0) || (one_left && grads.ready);
  end

  // Output channel.
  always_comb begin
    grads.valid       = (valid != '0);
    grads.grad_x      = entry[slot].grad_x;
    grads.grad_y      = entry[slot].grad_y;
    grads.out_row     = entry[slot].row;
    grads.out_col     = entry[slot].col;
    grads.last_of_run = one_left;
    grads.frame_end   = one_left && frame_end;
  end

  // Pending flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (load) begin
      valid <= bundle.valid;
    end else if (take) begin
      valid[slot] <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      entry     <= bundle.entry;
      frame_end <= bundle.frame_end;
    end
  end

endmodule
